### src/cdms_pkg.sv
// Package for the decimal-degrees to degrees/minutes/seconds unit.
// Holds the pipeline depth, the scaling constants and the per-stage enable struct.
// No dependencies.
package cdms_pkg;

  localparam int unsigned NUM_STAGES = 9;

  localparam logic [31:0] UNITS_PER_DEG = 32'd10000000;
  localparam logic [31:0] RECIP_MULT    = 32'd3602879702;
  localparam int unsigned RECIP_SHIFT   = 55;
  localparam int unsigned PROD_W        = 63;

  localparam logic [30:0] LAT_LIMIT = 31'd900000000;
  localparam logic [30:0] LON_LIMIT = 31'd1800000000;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } cdms_adv_t;

endpackage

### src/cdms_if.sv
// Channel interfaces of the coordinate unit: input word and result word.
// Depends on nothing.
interface cdms_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] lat_raw;
  logic signed [31:0] lon_raw;

  modport source (output valid, output lat_raw, output lon_raw, input ready);
  modport sink (input valid, input lat_raw, input lon_raw, output ready);
endinterface

interface cdms_out_if;
  logic       valid;
  logic       ready;
  logic       lat_south;
  logic [6:0] lat_deg;
  logic [5:0] lat_min;
  logic [5:0] lat_sec;
  logic       lon_west;
  logic [7:0] lon_deg;
  logic [5:0] lon_min;
  logic [5:0] lon_sec;

  modport source (output valid, output lat_south, output lat_deg, output lat_min,
                  output lat_sec, output lon_west, output lon_deg, output lon_min,
                  output lon_sec, input ready);
  modport sink (input valid, input lat_south, input lat_deg, input lat_min,
                input lat_sec, input lon_west, input lon_deg, input lon_min,
                input lon_sec, output ready);
endinterface

### src/cdms_ctrl.sv
// Pipeline control: one valid bit per stage and the per-stage load enables.
// Depends on cdms_pkg.
module cdms_ctrl
  import cdms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cdms_adv_t adv
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or when its word moves on.
  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  always_comb begin
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_nxt[i] = en[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign adv.en    = en;
  assign in_ready  = en[0];
  assign out_valid = valid_r[NUM_STAGES-1];

endmodule

### src/cdms_split.sv
// Datapath for one coordinate: clamp, magnitude, then degrees, minutes and
// seconds by reciprocal multiplication over nine register stages. Depends on cdms_pkg.
module cdms_split
  import cdms_pkg::*;
(
  input  logic               clk,
  input  cdms_adv_t          adv,
  input  logic signed [31:0] coord,
  input  logic [30:0]        limit,
  output logic               hemi,
  output logic [7:0]         deg,
  output logic [5:0]         min,
  output logic [5:0]         sec
);

  logic signed [31:0] lim_pos;
  logic signed [31:0] lim_neg;
  logic signed [31:0] clamped;
  logic [31:0]        mag;

  logic              hemi0_r, hemi1_r, hemi2_r, hemi3_r, hemi4_r, hemi5_r, hemi6_r, hemi7_r;
  logic              hemi8_r;
  logic [30:0]       mag0_r, mag1_r;
  logic [PROD_W-1:0] prod1_r, prod4_r, prod7_r;
  logic [PROD_W-1:0] prod1_nxt, prod4_nxt, prod7_nxt;
  logic [7:0]        deg2_r, deg3_r, deg4_r, deg5_r, deg6_r, deg7_r, deg8_r;
  logic [7:0]        deg2_nxt;
  logic [23:0]       rem2_r, rem5_r;
  logic [31:0]       back2, back5;
  logic [30:0]       diff2;
  logic [29:0]       diff5;
  logic [29:0]       scl3_r, scl4_r, scl6_r;
  logic [5:0]        min5_r, min6_r, min7_r, min8_r;
  logic [5:0]        min5_nxt;
  logic [5:0]        sec8_r;

  always_comb begin
    lim_pos = signed'({1'b0, limit});
    lim_neg = -lim_pos;
    priority if (coord > lim_pos) begin
      clamped = lim_pos;
    end else if (coord < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = coord;
    end
    mag = (clamped < 0) ? unsigned'(-clamped) : unsigned'(clamped);
  end

  assign prod1_nxt = PROD_W'(mag0_r) * PROD_W'(RECIP_MULT);
  assign deg2_nxt  = prod1_r[PROD_W-1:RECIP_SHIFT];
  assign back2     = 32'(deg2_nxt) * UNITS_PER_DEG;
  assign diff2     = mag1_r - back2[30:0];
  assign prod4_nxt = PROD_W'(scl3_r) * PROD_W'(RECIP_MULT);
  assign min5_nxt  = prod4_r[RECIP_SHIFT+5:RECIP_SHIFT];
  assign back5     = 32'(min5_nxt) * UNITS_PER_DEG;
  assign diff5     = scl4_r - back5[29:0];
  assign prod7_nxt = PROD_W'(scl6_r) * PROD_W'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      hemi0_r <= !(clamped > 0);
      mag0_r  <= mag[30:0];
    end
    if (adv.en[1]) begin
      hemi1_r <= hemi0_r;
      mag1_r  <= mag0_r;
      prod1_r <= prod1_nxt;
    end
    if (adv.en[2]) begin
      hemi2_r <= hemi1_r;
      deg2_r  <= deg2_nxt;
      rem2_r  <= diff2[23:0];
    end
    if (adv.en[3]) begin
      hemi3_r <= hemi2_r;
      deg3_r  <= deg2_r;
      scl3_r  <= {rem2_r, 6'b0} - {4'b0, rem2_r, 2'b0};
    end
    if (adv.en[4]) begin
      hemi4_r <= hemi3_r;
      deg4_r  <= deg3_r;
      scl4_r  <= scl3_r;
      prod4_r <= prod4_nxt;
    end
    if (adv.en[5]) begin
      hemi5_r <= hemi4_r;
      deg5_r  <= deg4_r;
      min5_r  <= min5_nxt;
      rem5_r  <= diff5[23:0];
    end
    if (adv.en[6]) begin
      hemi6_r <= hemi5_r;
      deg6_r  <= deg5_r;
      min6_r  <= min5_r;
      scl6_r  <= {rem5_r, 6'b0} - {4'b0, rem5_r, 2'b0};
    end
    if (adv.en[7]) begin
      hemi7_r <= hemi6_r;
      deg7_r  <= deg6_r;
      min7_r  <= min6_r;
      prod7_r <= prod7_nxt;
    end
    if (adv.en[8]) begin
      hemi8_r <= hemi7_r;
      deg8_r  <= deg7_r;
      min8_r  <= min7_r;
      sec8_r  <= prod7_r[RECIP_SHIFT+5:RECIP_SHIFT];
    end
  end

  assign hemi = hemi8_r;
  assign deg  = deg8_r;
  assign min  = min8_r;
  assign sec  = sec8_r;

endmodule

### src/coord_to_deg_min_sec_unit.sv
// Decimal degrees to degrees, minutes and seconds for a latitude/longitude word.
// Pipeline: 9 register stages.
// Throughput: one word per cycle while out_ch.ready is high; a low ready stalls the chain.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// Depends on cdms_pkg, cdms_if, cdms_ctrl and cdms_split.
module coord_to_deg_min_sec_unit
  import cdms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cdms_in_if.sink    in_ch,
  cdms_out_if.source out_ch
);

  cdms_adv_t  adv;
  logic [7:0] lat_deg_w;

  cdms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .adv       (adv)
  );

  cdms_split u_lat (
    .clk   (clk),
    .adv   (adv),
    .coord (32'(in_ch.lat_raw)),
    .limit (LAT_LIMIT),
    .hemi  (out_ch.lat_south),
    .deg   (lat_deg_w),
    .min   (out_ch.lat_min),
    .sec   (out_ch.lat_sec)
  );

  cdms_split u_lon (
    .clk   (clk),
    .adv   (adv),
    .coord (in_ch.lon_raw),
    .limit (LON_LIMIT),
    .hemi  (out_ch.lon_west),
    .deg   (out_ch.lon_deg),
    .min   (out_ch.lon_min),
    .sec   (out_ch.lon_sec)
  );

  assign out_ch.lat_deg = lat_deg_w[6:0];

  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.lat_min < 6'd60) && (out_ch.lat_sec < 6'd60) &&
                     (out_ch.lon_min < 6'd60) && (out_ch.lon_sec < 6'd60) &&
                     (lat_deg_w <= 8'd90) && (out_ch.lon_deg <= 8'd180))
    else $error("result word has a field out of range");

  a_limit_is_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((lat_deg_w == 8'd90) || (out_ch.lon_deg == 8'd180))) |->
      ((lat_deg_w != 8'd90) || ((out_ch.lat_min == 6'd0) && (out_ch.lat_sec == 6'd0))) &&
      ((out_ch.lon_deg != 8'd180) ||
       ((out_ch.lon_min == 6'd0) && (out_ch.lon_sec == 6'd0))))
    else $error("clamped limit shows nonzero minutes or seconds");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule
